### src/pal_pkg.sv
// Shared types and constants for the positional array list.
// Holds operation codes, field widths and controller/datapath interface structs.
// No dependencies.
package pal_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 6;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic cap;
        logic k_init;
        logic rd_move;
        logic wr_move;
        logic wr_new;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic is_get;
        logic is_ins;
        logic move_more;
    } t_sts;

endpackage

### src/positional_array_list.sv
// Each operation runs through controller states: check, read, entry moves (a read state
// and a write state per moved entry) and result; the result waits while an output beat is
// still pending. A new input beat is accepted only after the previous result is issued.
// Reset: synchronous active low; clears length to zero and control state; entries undefined.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_new_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_status,
    output logic signed [DATA_W-1:0] o_item_value,
    output logic [LEN_W-1:0]         o_list_length
);

    t_cmd cmd;
    t_sts sts;

    pal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_item_value  (o_item_value),
        .o_list_length (o_list_length)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_item_value == '0))
        else $error("error beat carries nonzero value");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish && o_out_valid) |-> i_out_ready)
        else $error("result overwrote pending beat");
`endif

endmodule

### src/pal_dp.sv
// Datapath of the positional array list: entry memory, length count, move pointer.
// Executes commands from pal_ctrl and reports status back.
// Depends on pal_pkg.
module pal_dp
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_new_value,
    output t_sts                     o_sts,
    output logic                     o_status,
    output logic signed [DATA_W-1:0] o_item_value,
    output logic [LEN_W-1:0]         o_list_length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]   r_op;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [XW-1:0]     r_k;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_got;
    logic              r_status;
    logic [DATA_W-1:0] r_item;
    logic [LEN_W-1:0]  r_len;

    logic [XW-1:0]     posx;
    logic [XW-1:0]     cntx;
    logic [XW-1:0]     km1;
    logic [XW-1:0]     pm1;
    logic              err;
    logic              is_get;
    logic              is_ins;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign posx   = XW'(r_pos);
    assign cntx   = XW'(r_cnt);
    assign km1    = r_k - XW'(1);
    assign pm1    = posx - XW'(1);
    assign is_get = (r_op == OP_GET);
    assign is_ins = (r_op == OP_INSERT);

    always_comb begin
        case (r_op)
            OP_GET, OP_DELETE: err = (posx == '0) || (posx > cntx);
            OP_INSERT:         err = (cntx >= XW'(DEPTH)) || (posx == '0)
                                     || (posx > (cntx + XW'(1)));
            default:           err = 1'b1;
        endcase
    end

    assign o_sts.err       = err;
    assign o_sts.is_get    = is_get;
    assign o_sts.is_ins    = is_ins;
    assign o_sts.move_more = is_ins ? (r_k >= posx) : (r_k < cntx);

    assign rd_en   = i_cmd.rd_pos | i_cmd.rd_move;
    assign rd_addr = i_cmd.rd_pos ? pm1[AW-1:0] : (is_ins ? km1[AW-1:0] : r_k[AW-1:0]);
    assign wr_en   = i_cmd.wr_move | i_cmd.wr_new;
    assign wr_addr = i_cmd.wr_new ? pm1[AW-1:0] : (is_ins ? r_k[AW-1:0] : km1[AW-1:0]);
    assign wr_data = i_cmd.wr_new ? r_val : r_rdata;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.finish && !err) begin
            if (is_ins) begin
                n_cnt = r_cnt + CW'(1);
            end else if (!is_get) begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= i_new_value;
        end
        if (i_cmd.cap) begin
            r_got <= r_rdata;
        end
        if (i_cmd.k_init) begin
            r_k <= is_ins ? cntx : posx;
        end else if (i_cmd.wr_move) begin
            r_k <= is_ins ? km1 : (r_k + XW'(1));
        end
        if (i_cmd.finish) begin
            r_status <= err;
            r_item   <= (!err && !is_ins) ? r_got : '0;
            r_len    <= LEN_W'(n_cnt);
        end
    end

    assign o_status      = r_status;
    assign o_item_value  = r_item;
    assign o_list_length = r_len;

endmodule

### src/pal_ctrl.sv
// Controller of the positional array list: sequences check, read, entry moves and result.
// Owns both handshakes and the output valid flag; drives pal_dp by commands.
// Depends on pal_pkg.
module pal_ctrl
    import pal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_CAP    = 6'b000100,
        S_MV_CHK = 6'b001000,
        S_MV_WR  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else if (i_sts.is_ins) begin
                    o_cmd.k_init = 1'b1;
                    n_state      = S_MV_CHK;
                end else begin
                    o_cmd.rd_pos = 1'b1;
                    n_state      = S_CAP;
                end
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                if (i_sts.is_get) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.k_init = 1'b1;
                    n_state      = S_MV_CHK;
                end
            end
            S_MV_CHK: begin
                if (i_sts.move_more) begin
                    o_cmd.rd_move = 1'b1;
                    n_state       = S_MV_WR;
                end else begin
                    o_cmd.wr_new = i_sts.is_ins;
                    n_state      = S_FIN;
                end
            end
            S_MV_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_MV_CHK;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### tb/positional_array_list_check.sv
// Checker for the positional array list: watches both channels, keeps its own copy
// of the list, predicts one result per input beat and compares each output beat.
// Depends on pal_pkg for widths, depth and operation codes.
module positional_array_list_check
    import pal_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_new_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_status,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic [LEN_W-1:0]         i_list_length,
    output int                       o_fail_count,
    output int                       o_open_results
);

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         length;
    } t_list_result;

    logic signed [DATA_W-1:0] shadow_entries [DEPTH_DEF];
    int                       shadow_count;
    t_list_result             results_due [$];
    int                       mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] op_bits,
                                                   input int pos,
                                                   input logic signed [DATA_W-1:0] val);
        t_list_result res;
        int           k;
        res = '{status: 1'b1, value: '0, length: '0};
        case (t_op'(op_bits))
            OP_GET: begin
                if (pos >= 1 && pos <= shadow_count) begin
                    res.status = 1'b0;
                    res.value  = shadow_entries[pos-1];
                end
            end
            OP_INSERT: begin
                if (shadow_count < DEPTH_DEF && pos >= 1 && pos <= shadow_count + 1) begin
                    for (k = shadow_count; k > pos - 1; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[pos-1] = val;
                    shadow_count++;
                    res.status = 1'b0;
                end
            end
            OP_DELETE: begin
                if (pos >= 1 && pos <= shadow_count) begin
                    res.value = shadow_entries[pos-1];
                    for (k = pos; k < shadow_count; k++)
                        shadow_entries[k-1] = shadow_entries[k];
                    shadow_count--;
                    res.status = 1'b0;
                end
            end
            default: ;
        endcase
        res.length = LEN_W'(shadow_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = results_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  i_status, want.status));
                    if (i_item_value !== want.value)
                        report_mismatch($sformatf("item_value %0d, expected %0d",
                                                  i_item_value, want.value));
                    if (i_list_length !== want.length)
                        report_mismatch($sformatf("list_length %0d, expected %0d",
                                                  i_list_length, want.length));
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(apply_list_op(i_operation, int'(i_position),
                                                    i_new_value));
        end
        o_open_results <= results_due.size();
    end

endmodule

### tb/positional_array_list_test.sv
// Top of the positional array list testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on pal_pkg, positional_array_list and
// positional_array_list_check.
module positional_array_list_test
    import pal_pkg::*;
();

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic [OP_W-1:0]          operation = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] new_value = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic                     status;
    logic signed [DATA_W-1:0] item_value;
    logic [LEN_W-1:0]         list_length;
    int                       fail_count;
    int                       open_results;

    int fill_guess = 0;
    int burst_left = 0;
    bit hold_off_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    positional_array_list i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_operation  (operation),
        .i_position   (position),
        .i_new_value  (new_value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_item_value (item_value),
        .o_list_length(list_length)
    );

    positional_array_list_check i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_operation   (operation),
        .i_position    (position),
        .i_new_value   (new_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_item_value  (item_value),
        .i_list_length (list_length),
        .o_fail_count  (fail_count),
        .o_open_results(open_results)
    );

    // hold each beat until accepted, then track the list length for position choice
    task automatic send_beat(input logic [OP_W-1:0] op, input int pos,
                             input logic signed [DATA_W-1:0] val);
        in_valid  <= 1'b1;
        operation <= op;
        position  <= POS_W'(pos);
        new_value <= val;
        do @(posedge i_clk); while (!in_ready);
        if (op == OP_INSERT && fill_guess < DEPTH_DEF && pos >= 1 && pos <= fill_guess + 1)
            fill_guess++;
        else if (op == OP_DELETE && pos >= 1 && pos <= fill_guess)
            fill_guess--;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (open_results == 0);
        @(posedge i_clk);
    endtask

    // bias: 0 fill, 1 mixed, 2 drain
    task automatic random_phase(input int bias, input int n, input bit with_hold);
        int                 i;
        int                 r;
        int                 pos;
        logic [OP_W-1:0]    op;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            case (bias)
                0:       op = r < 60 ? OP_INSERT : r < 80 ? OP_GET : r < 97 ? OP_DELETE : OP_UNUSED;
                1:       op = r < 35 ? OP_INSERT : r < 65 ? OP_GET : r < 97 ? OP_DELETE : OP_UNUSED;
                default: op = r < 15 ? OP_INSERT : r < 40 ? OP_GET : r < 97 ? OP_DELETE : OP_UNUSED;
            endcase
            if ($urandom_range(0, 9) < 8) begin
                if (op == OP_INSERT)
                    pos = $urandom_range(1, fill_guess + 1);
                else
                    pos = fill_guess == 0 ? 1 : $urandom_range(1, fill_guess);
            end else begin
                pos = $urandom_range(0, 63);
            end
            if (with_hold && i == n / 3)
                hold_off_req = 1'b1;
            send_beat(op, pos, $urandom);
        end
        drain_results();
    endtask

    // receiver: ready patterns of random span, one long hold-off on request
    initial begin
        int span;
        int mode;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 150);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int rep;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(OP_GET, 1, 32'sd5);
        send_beat(OP_DELETE, 1, '0);
        send_beat(OP_INSERT, 0, 32'sd9);
        send_beat(OP_INSERT, 2, 32'sd9);
        send_beat(OP_INSERT, 1, 32'sh7FFF_FFFF);
        send_beat(OP_INSERT, 1, 32'sh8000_0000);
        send_beat(OP_INSERT, 3, -32'sd1);
        send_beat(OP_INSERT, 2, 32'sd0);
        send_beat(OP_INSERT, 6, 32'sd7);
        send_beat(OP_GET, 1, '0);
        send_beat(OP_GET, 4, '0);
        send_beat(OP_GET, 5, '0);
        send_beat(OP_GET, 0, '0);
        send_beat(OP_GET, 63, -32'sd1);
        send_beat(OP_UNUSED, 1, 32'sh5555_AAAA);
        send_beat(OP_UNUSED, 0, '0);
        send_beat(OP_DELETE, 63, '0);
        send_beat(OP_DELETE, 0, '0);
        send_beat(OP_DELETE, 2, '0);
        send_beat(OP_DELETE, 3, '0);
        send_beat(OP_DELETE, 1, '0);
        send_beat(OP_GET, 1, '0);
        send_beat(OP_DELETE, 1, '0);
        send_beat(OP_GET, 1, '0);
        drain_results();

        for (rep = 0; rep < 2; rep++) begin
            random_phase(0, 150, 1'b0);
            random_phase(1, 150, rep == 0);
            random_phase(2, 150, 1'b0);
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && open_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
